// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // Default sizing
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed port widths
    localparam int PORT_VALUE_W  = 16;
    localparam int PORT_STATUS_W = 2;
    localparam int PORT_COUNT_W  = 5;

    // Command codes
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_POP = 1'b1;

    // Status codes
    localparam logic [PORT_STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [PORT_STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [PORT_STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic put_en;
        logic pop_en;
    } cell_ctl_t;

endpackage

// File: hw/rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

// Sorted minimum priority queue built as a chain of DEPTH compare-and-shift
// cells, smallest value in cell 0. Pulse start with command (put or pop) and
// value; busy never rises, so an item can be issued every clock cycle. Each
// item produces exactly one result in the next cycle: done is high for that
// single cycle, and status, popped_value, front_value and entry_count are
// valid only then. The receiver cannot stall, so capture the result on the
// cycle done is high. All cells compare against the new value and shift in
// the same cycle, so the rate is one item per cycle for any DEPTH; the count
// register holds which cells are occupied. A put on a full queue reports
// full and changes nothing; a pop on an empty queue reports empty and
// changes nothing. Equal values leave in arrival order.
// Cell contents are not cleared at reset; only occupied cells are ever read.
module sorted_priority_queue_unit #(
    parameter int DEPTH       = spq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic [spq_pkg::PORT_VALUE_W-1:0]   value,
    output logic                               done,
    output logic [spq_pkg::PORT_STATUS_W-1:0]  status,
    output logic [spq_pkg::PORT_VALUE_W-1:0]   popped_value,
    output logic [spq_pkg::PORT_VALUE_W-1:0]   front_value,
    output logic [spq_pkg::PORT_COUNT_W-1:0]   entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = spq_pkg::PORT_VALUE_W;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic [VALUE_WIDTH-1:0] in_val;
    spq_pkg::cell_ctl_t     ctl;

    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]       cell_keep;
    logic [DEPTH-1:0]       cell_use;

    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic                              done_reg;
    logic [spq_pkg::PORT_STATUS_W-1:0] status_reg;
    logic [spq_pkg::PORT_STATUS_W-1:0] status_next;
    logic [VALUE_WIDTH-1:0]            popped_reg;
    logic [VALUE_WIDTH-1:0]            popped_next;
    logic [VALUE_WIDTH-1:0]            front_raw;

    // Nothing to wait on: always ready for the next item
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Fit the port value to the stored width
    generate
        if (VALUE_WIDTH >= PW)
        begin : g_in_wide
            assign in_val = VALUE_WIDTH'(value);
        end
        else
        begin : g_in_narrow
            assign in_val = value[VALUE_WIDTH-1:0];
        end
    endgenerate

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        ctl.put_en = accept && (command == spq_pkg::CMD_PUT) && !full;
        ctl.pop_en = accept && (command == spq_pkg::CMD_POP) && !empty;
    end

    // Status, popped value and count for the item being accepted
    always_comb
    begin
        status_next = spq_pkg::STATUS_DONE;
        popped_next = '0;
        count_next  = count_reg;
        if (accept)
        begin
            case (command)
                spq_pkg::CMD_PUT:
                begin
                    if (full)
                    begin
                        status_next = spq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                spq_pkg::CMD_POP:
                begin
                    if (empty)
                    begin
                        status_next = spq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        popped_next = cell_value[0];
                        count_next  = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = spq_pkg::STATUS_DONE;
                end
            endcase
        end
    end

    // Chain of cells: each sees its neighbors' values and the left keep flag
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                   prev_keep;
            logic [VALUE_WIDTH-1:0] prev_value;
            logic [VALUE_WIDTH-1:0] next_value;

            assign cell_use[i] = (count_reg > CW'(i));

            if (i == 0)
            begin : g_head
                assign prev_keep  = 1'b1;
                assign prev_value = in_val;
            end
            else
            begin : g_body
                assign prev_keep  = cell_keep[i-1];
                assign prev_value = cell_value[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_value = '0;
            end
            else
            begin : g_mid
                assign next_value = cell_value[i+1];
            end

            spq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .in_value   (in_val),
                .in_use     (cell_use[i]),
                .prev_keep  (prev_keep),
                .prev_value (prev_value),
                .next_value (next_value),
                .value      (cell_value[i]),
                .keep       (cell_keep[i])
            );
        end
    endgenerate

    // Hold count and the result registers; done strobes for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= spq_pkg::STATUS_DONE;
            popped_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (accept)
            begin
                status_reg <= status_next;
                popped_reg <= popped_next;
            end
        end
    end

    // Front and count come straight from the state left by the last item
    assign front_raw = (count_reg != '0) ? cell_value[0] : '0;

    generate
        if (VALUE_WIDTH >= PW)
        begin : g_out_wide
            assign popped_value = popped_reg[PW-1:0];
            assign front_value  = front_raw[PW-1:0];
        end
        else
        begin : g_out_narrow
            assign popped_value = PW'(popped_reg);
            assign front_value  = PW'(front_raw);
        end

        if (CW >= spq_pkg::PORT_COUNT_W)
        begin : g_cnt_wide
            assign entry_count = count_reg[spq_pkg::PORT_COUNT_W-1:0];
        end
        else
        begin : g_cnt_narrow
            assign entry_count = spq_pkg::PORT_COUNT_W'(count_reg);
        end
    endgenerate

    assign done   = done_reg;
    assign status = status_reg;

    // Count never passes the number of cells
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above DEPTH");

    // Every accepted item yields a strobe in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted item without result");

    // A successful put grows the count by one
    a_put_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.put_en |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("put did not grow count");

    // The front two occupied cells stay in order
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (cell_value[0] <= cell_value[1]))
        else $error("chain out of order");

endmodule

// File: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted chain. On a put, keep the own value if it is in use
// and not larger than the new value; otherwise take the new value (left
// neighbor kept) or the left neighbor's value (shift right). On a pop, take
// the right neighbor's value (shift left).
module spq_cell #(
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  spq_pkg::cell_ctl_t     ctl,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  logic                   in_use,
    input  logic                   prev_keep,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    input  logic [VALUE_WIDTH-1:0] next_value,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   keep
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    assign keep  = in_use && (value_reg <= in_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.put_en)
        begin
            if (!keep)
            begin
                value_next = prev_keep ? in_value : prev_value;
            end
        end
        else if (ctl.pop_en)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
